[design/ps2s1_pkg.sv]
`default_nettype none

package ps2s1_pkg;

    // Prefix bytes of scan code set 1.
    localparam logic [7:0] SCAN_PREFIX_EXT   = 8'hE0;
    localparam logic [7:0] SCAN_PREFIX_PAUSE = 8'hE1;

    // Bit 7 of a key byte marks a break; bit 7 of a key code marks an extended key.
    localparam int unsigned BREAK_BIT = 7;
    localparam logic [7:0]  EXT_FLAG  = 8'h80;

    // Seven-bit key numbers with special handling.
    localparam logic [6:0] KEY_CTRL   = 7'h1D;
    localparam logic [6:0] KEY_LSHIFT = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT = 7'h36;
    localparam logic [6:0] KEY_ALT    = 7'h38;
    localparam logic [6:0] KEY_CAPS   = 7'h3A;
    localparam logic [6:0] KEY_NUM    = 7'h45;
    localparam logic [6:0] KEY_SCROLL = 7'h46;
    localparam logic [6:0] KEY_LGUI   = 7'h5B;
    localparam logic [6:0] KEY_RGUI   = 7'h5C;

    // Positions of the modifier bits.
    localparam logic [2:0] MOD_LCTRL  = 3'd0;
    localparam logic [2:0] MOD_LSHIFT = 3'd1;
    localparam logic [2:0] MOD_LALT   = 3'd2;
    localparam logic [2:0] MOD_LGUI   = 3'd3;
    localparam logic [2:0] MOD_RCTRL  = 3'd4;
    localparam logic [2:0] MOD_RSHIFT = 3'd5;
    localparam logic [2:0] MOD_RALT   = 3'd6;
    localparam logic [2:0] MOD_RGUI   = 3'd7;

    // Positions of the lock bits.
    localparam logic [1:0] LOCK_CAPS   = 2'd0;
    localparam logic [1:0] LOCK_NUM    = 2'd1;
    localparam logic [1:0] LOCK_SCROLL = 2'd2;

    typedef enum logic [1:0] {
        PFX_NONE    = 2'd0,
        PFX_EXT     = 2'd1,
        PFX_SWALLOW = 2'd2
    } prefix_t;

endpackage

`default_nettype wire

[design/ps2s1_if.sv]
`default_nettype none

// Raw scan byte channel.
interface ps2s1_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface

// Decoded key event channel.
interface ps2s1_event_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_code;
    logic       pressed;
    logic [7:0] modifier_bits;
    logic [2:0] lock_bits;

    modport source (output valid, output key_code, output pressed,
                    output modifier_bits, output lock_bits, input ready);
    modport sink   (input valid, input key_code, input pressed,
                    input modifier_bits, input lock_bits, output ready);
endinterface

// Configuration write channel for the single control register.
interface ps2s1_cfg_if;
    logic valid;
    logic ready;
    logic events_enabled;

    modport source (output valid, output events_enabled, input ready);
    modport sink   (input valid, input events_enabled, output ready);
endinterface

`default_nettype wire

[design/ps2_set1_scancode_decoder_top.sv]
`default_nettype none

// Channel     Direction  Payload
// ---------   ---------  ------------------------------------------------
// scan        in         scan_byte[7:0]
// key_event   out        key_code[7:0], pressed, modifier_bits[7:0],
//                        lock_bits[2:0]
// cfg         in         events_enabled (write only)
//
// Each scan byte is decoded in the cycle it is accepted and its event, if any,
// appears in the result register on the next cycle.
// One byte is accepted in every cycle while the result register is empty or is
// being emptied in the same cycle; only a stalled key_event sink holds scan off.
// Reset clears the prefix state, the modifier and lock bits, the enable and
// the result valid flag, and the block takes a byte as soon as reset ends.

module ps2_set1_scancode_decoder_top (
    input  wire logic      clk,
    input  wire logic      rst_n,
    ps2s1_scan_if.sink     scan,
    ps2s1_event_if.source  key_event,
    ps2s1_cfg_if.sink      cfg
);

    // Decoder state, updated only when a scan transaction completes; the enable follows cfg writes.
    ps2s1_pkg::prefix_t prefix_reg, prefix_next;
    logic [7:0]         mods_reg, mods_next;
    logic [2:0]         locks_reg, locks_next;
    logic               enabled_reg;

    // Result register; it doubles as the stage that parts the two sides.
    logic               res_valid_reg, res_valid_next;
    logic [7:0]         res_code_reg;
    logic               res_pressed_reg;
    logic [7:0]         res_mods_reg;
    logic [2:0]         res_locks_reg;

    logic               scan_accept;
    logic               event_taken;
    logic               emit;
    logic [7:0]         emit_code;
    logic [6:0]         key;
    logic               make;

    // The result slot is free when empty or when its event leaves this cycle.
    assign scan.ready  = !res_valid_reg || key_event.ready;
    assign scan_accept = scan.valid && scan.ready;
    assign event_taken = res_valid_reg && key_event.ready;

    // The configuration register can always be written.
    assign cfg.ready = 1'b1;

    assign key  = scan.scan_byte[6:0];
    assign make = !scan.scan_byte[ps2s1_pkg::BREAK_BIT];

    // Byte decode: prefix tracking, modifier and lock updates, event selection.
    always_comb
    begin
        prefix_next = prefix_reg;
        mods_next   = mods_reg;
        locks_next  = locks_reg;
        emit        = 1'b0;
        emit_code   = {1'b0, key};

        if (scan.scan_byte == ps2s1_pkg::SCAN_PREFIX_EXT)
        begin
            prefix_next = ps2s1_pkg::PFX_EXT;
        end
        else if (scan.scan_byte == ps2s1_pkg::SCAN_PREFIX_PAUSE)
        begin
            prefix_next = ps2s1_pkg::PFX_SWALLOW;
        end
        else
        begin
            case (prefix_reg)
                ps2s1_pkg::PFX_SWALLOW:
                begin
                    // The byte after the pause prefix is dropped.
                    prefix_next = ps2s1_pkg::PFX_NONE;
                end
                ps2s1_pkg::PFX_NONE:
                begin
                    case (key)
                        ps2s1_pkg::KEY_CTRL:   mods_next[ps2s1_pkg::MOD_LCTRL]  = make;
                        ps2s1_pkg::KEY_LSHIFT: mods_next[ps2s1_pkg::MOD_LSHIFT] = make;
                        ps2s1_pkg::KEY_RSHIFT: mods_next[ps2s1_pkg::MOD_RSHIFT] = make;
                        ps2s1_pkg::KEY_ALT:    mods_next[ps2s1_pkg::MOD_LALT]   = make;
                        ps2s1_pkg::KEY_CAPS:
                            locks_next[ps2s1_pkg::LOCK_CAPS] =
                                locks_reg[ps2s1_pkg::LOCK_CAPS] ^ make;
                        ps2s1_pkg::KEY_NUM:
                            locks_next[ps2s1_pkg::LOCK_NUM] =
                                locks_reg[ps2s1_pkg::LOCK_NUM] ^ make;
                        ps2s1_pkg::KEY_SCROLL:
                            locks_next[ps2s1_pkg::LOCK_SCROLL] =
                                locks_reg[ps2s1_pkg::LOCK_SCROLL] ^ make;
                        default:               emit = 1'b1;
                    endcase
                end
                default:
                begin
                    // Extended prefix pending; the unused code behaves the same.
                    prefix_next = ps2s1_pkg::PFX_NONE;
                    emit_code   = {1'b0, key} | ps2s1_pkg::EXT_FLAG;
                    case (key)
                        ps2s1_pkg::KEY_CTRL: mods_next[ps2s1_pkg::MOD_RCTRL] = make;
                        ps2s1_pkg::KEY_ALT:  mods_next[ps2s1_pkg::MOD_RALT]  = make;
                        ps2s1_pkg::KEY_LGUI: mods_next[ps2s1_pkg::MOD_LGUI]  = make;
                        ps2s1_pkg::KEY_RGUI: mods_next[ps2s1_pkg::MOD_RGUI]  = make;
                        default:             emit = 1'b1;
                    endcase
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (scan_accept)
        begin
            res_valid_next = emit && enabled_reg;
        end
        else if (event_taken)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg    <= ps2s1_pkg::PFX_NONE;
            mods_reg      <= '0;
            locks_reg     <= '0;
            enabled_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (scan_accept)
            begin
                prefix_reg <= prefix_next;
                mods_reg   <= mods_next;
                locks_reg  <= locks_next;
            end
            if (cfg.valid && cfg.ready)
            begin
                enabled_reg <= cfg.events_enabled;
            end
        end
    end

    // Event payload; the modifiers and locks are the values before this byte,
    // which an event-producing byte never changes.
    always_ff @(posedge clk)
    begin
        if (scan_accept)
        begin
            res_code_reg    <= emit_code;
            res_pressed_reg <= make;
            res_mods_reg    <= mods_reg;
            res_locks_reg   <= locks_reg;
        end
    end

    assign key_event.valid         = res_valid_reg;
    assign key_event.key_code      = res_code_reg;
    assign key_event.pressed       = res_pressed_reg;
    assign key_event.modifier_bits = res_mods_reg;
    assign key_event.lock_bits     = res_locks_reg;

endmodule

`default_nettype wire

[design/ps2s1_checker.sv]
`default_nettype none

module ps2s1_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       scan_valid,
    input wire logic       scan_ready,
    input wire logic [7:0] scan_byte,
    input wire logic       ev_valid,
    input wire logic       ev_ready,
    input wire logic [7:0] ev_key_code,
    input wire logic       ev_pressed,
    input wire logic [7:0] ev_modifier_bits,
    input wire logic [2:0] ev_lock_bits
);

    logic scan_accept;
    logic ev_free;

    assign scan_accept = scan_valid && scan_ready;
    assign ev_free     = !ev_valid || ev_ready;

    // A stalled event holds its payload.
    a_event_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && !ev_ready |=>
            ev_valid && $stable(ev_key_code) && $stable(ev_pressed)
            && $stable(ev_modifier_bits) && $stable(ev_lock_bits))
        else $error("key event changed while stalled");

    // An empty result register never holds off the scan side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !ev_valid |-> scan_ready)
        else $error("scan stalled with no pending event");

    // Prefix bytes never produce an event.
    a_prefix_silent: assert property (@(posedge clk) disable iff (!rst_n)
        scan_accept && ev_free
        && (scan_byte == ps2s1_pkg::SCAN_PREFIX_EXT
            || scan_byte == ps2s1_pkg::SCAN_PREFIX_PAUSE)
        |=> !ev_valid)
        else $error("event produced by a prefix byte");

    // No transaction in means no new event out.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !scan_accept && ev_free |=> !ev_valid)
        else $error("event appeared without a scan byte");

    // Modifier and lock keys are absorbed, never reported.
    a_no_modifier_event: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid |-> !(ev_key_code == {1'b0, ps2s1_pkg::KEY_CTRL}
            || ev_key_code == {1'b0, ps2s1_pkg::KEY_LSHIFT}
            || ev_key_code == {1'b0, ps2s1_pkg::KEY_RSHIFT}
            || ev_key_code == {1'b0, ps2s1_pkg::KEY_ALT}
            || ev_key_code == {1'b0, ps2s1_pkg::KEY_CAPS}
            || ev_key_code == {1'b0, ps2s1_pkg::KEY_NUM}
            || ev_key_code == {1'b0, ps2s1_pkg::KEY_SCROLL}
            || ev_key_code == {1'b1, ps2s1_pkg::KEY_CTRL}
            || ev_key_code == {1'b1, ps2s1_pkg::KEY_ALT}
            || ev_key_code == {1'b1, ps2s1_pkg::KEY_LGUI}
            || ev_key_code == {1'b1, ps2s1_pkg::KEY_RGUI}))
        else $error("modifier or lock key reported as an event");

endmodule

bind ps2_set1_scancode_decoder_top ps2s1_checker u_ps2s1_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .scan_valid       (scan.valid),
    .scan_ready       (scan.ready),
    .scan_byte        (scan.scan_byte),
    .ev_valid         (key_event.valid),
    .ev_ready         (key_event.ready),
    .ev_key_code      (key_event.key_code),
    .ev_pressed       (key_event.pressed),
    .ev_modifier_bits (key_event.modifier_bits),
    .ev_lock_bits     (key_event.lock_bits)
);

`default_nettype wire
